// ===== rtl/twsched_pkg.sv =====
// ----------------------------------------------------------------------------
// twsched_pkg
// Shared types, codes and defaults for the timing wheel scheduler.
// ----------------------------------------------------------------------------
package twsched_pkg;

  // default sizes
  localparam int WHEEL_SLOTS_DEF = 256;
  localparam int SLOT_DEPTH_DEF  = 16;
  localparam int HEAP_DEPTH_DEF  = 64;
  localparam int TOKEN_BITS_DEF  = 16;

  // fixed field widths
  localparam int TIME_W  = 48;
  localparam int DELAY_W = 32;
  localparam int TOKEN_W = 16;

  // opcodes
  localparam logic [1:0] OP_ABS   = 2'd0;
  localparam logic [1:0] OP_DELAY = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_FIRED  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // decoded command between front and back
  typedef struct packed {
    logic [1:0]         op;
    logic [TIME_W-1:0]  target;
    logic [DELAY_W-1:0] delay;
    logic [TOKEN_W-1:0] token;
  } cmd_t;

  // heap order: due time first, then token
  function automatic logic earlier(input logic [TIME_W-1:0] a_due,
                                   input logic [TOKEN_W-1:0] a_tok,
                                   input logic [TIME_W-1:0] b_due,
                                   input logic [TOKEN_W-1:0] b_tok);
    earlier = (a_due != b_due) ? (a_due < b_due) : (a_tok < b_tok);
  endfunction

endpackage

// ===== rtl/twsched_if.sv =====
// ----------------------------------------------------------------------------
// twsched_if
// Valid/ready channels for schedule/tick items and for result items.
// ----------------------------------------------------------------------------
interface twsched_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [47:0] target_time;
  logic signed [31:0] delay;
  logic [15:0] token;

  modport source (output valid, opcode, target_time, delay, token, input ready);
  modport sink   (input valid, opcode, target_time, delay, token, output ready);
endinterface

interface twsched_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] out_token;
  logic [47:0] due_time;
  logic        last;

  modport source (output valid, kind, out_token, due_time, last, input ready);
  modport sink   (input valid, kind, out_token, due_time, last, output ready);
endinterface

// ===== rtl/timing_wheel_scheduler.sv =====
// Schedule item: offset and slot choice, then an append to the slot FIFO and a
// registered result; into the heap, a sift-up reads and compares the parent per level.
// Tick item: the current slot drains, one fired result per entry, then timers move
// from the heap top into the wheel, each with a sift-down. One item at a time; a two-entry
// queue decouples input. Reset (synchronous, active high) clears control state, then a
// pass zeroes the slot state memory; no item is accepted meanwhile.
// ----------------------------------------------------------------------------
// timing_wheel_scheduler
// Hashed timing wheel with an overflow min-heap: top level.
// ----------------------------------------------------------------------------
module timing_wheel_scheduler #(
  parameter int WHEEL_SLOTS = twsched_pkg::WHEEL_SLOTS_DEF,
  parameter int SLOT_DEPTH  = twsched_pkg::SLOT_DEPTH_DEF,
  parameter int HEAP_DEPTH  = twsched_pkg::HEAP_DEPTH_DEF,
  parameter int TOKEN_BITS  = twsched_pkg::TOKEN_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  twsched_in_if.sink    sched_in,
  twsched_out_if.source sched_out
);

  twsched_pkg::cmd_t cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  logic              clearing;

  // classify and queue
  twsched_front #(
    .TOKEN_BITS (TOKEN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .sched_in  (sched_in),
    .hold      (clearing),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // wheel and heap engine
  twsched_back #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .SLOT_DEPTH  (SLOT_DEPTH),
    .HEAP_DEPTH  (HEAP_DEPTH),
    .TOKEN_BITS  (TOKEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .sched_out (sched_out)
  );

endmodule

// ===== rtl/twsched_front.sv =====
// ----------------------------------------------------------------------------
// twsched_front
// Accepts items, drops unused opcodes, masks the token and queues commands
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module twsched_front #(
  parameter int TOKEN_BITS = twsched_pkg::TOKEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  twsched_in_if.sink          sched_in,
  input  logic                hold,
  output twsched_pkg::cmd_t   cmd,
  output logic                cmd_valid,
  input  logic                cmd_pop
);

  localparam logic [15:0] TOK_MASK = (TOKEN_BITS >= 16) ? 16'hFFFF :
                                     16'((32'd1 << TOKEN_BITS) - 32'd1);

  twsched_pkg::cmd_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       acc;
  logic       push;

  // accept unless clearing or the queue is full
  assign sched_in.ready = !hold && (cnt != 2'd2);
  assign acc  = sched_in.valid && sched_in.ready;
  assign push = acc && (sched_in.opcode != twsched_pkg::OP_NONE);

  assign cmd       = q[rp];
  assign cmd_valid = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        q[wp].op     <= sched_in.opcode;
        q[wp].target <= sched_in.target_time;
        q[wp].delay  <= sched_in.delay;
        q[wp].token  <= sched_in.token & TOK_MASK;
        wp           <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      case ({push, cmd_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/twsched_back.sv =====
// ----------------------------------------------------------------------------
// twsched_back
// Sequencer that owns the wheel, the slot state and the overflow heap, and
// drives the result register.
// ----------------------------------------------------------------------------
module twsched_back #(
  parameter int WHEEL_SLOTS = twsched_pkg::WHEEL_SLOTS_DEF,
  parameter int SLOT_DEPTH  = twsched_pkg::SLOT_DEPTH_DEF,
  parameter int HEAP_DEPTH  = twsched_pkg::HEAP_DEPTH_DEF,
  parameter int TOKEN_BITS  = twsched_pkg::TOKEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  twsched_pkg::cmd_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  output logic              clearing,
  twsched_out_if.source     sched_out
);

  localparam int PW   = $clog2(WHEEL_SLOTS);
  localparam int HW   = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CW   = $clog2(SLOT_DEPTH + 1);
  localparam int EAW  = $clog2(WHEEL_SLOTS * SLOT_DEPTH);
  localparam int HIW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int HCW  = $clog2(HEAP_DEPTH + 1);
  localparam int CXW  = HIW + 2;
  localparam int TW   = (TOKEN_BITS < 16) ? TOKEN_BITS : 16;
  localparam int TMW  = twsched_pkg::TIME_W;

  typedef struct packed {
    logic [TMW-1:0] due;
    logic [TW-1:0]  tok;
  } ent_t;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [CW-1:0] count;
  } sst_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_OFF, ST_SLOT, ST_SLOT_W, ST_PUSH,
    ST_UP, ST_UP_W, ST_UP_C, ST_EMIT,
    ST_TK_W, ST_TK, ST_TK_RD, ST_TK_W2, ST_TK_OUT, ST_TK_END,
    ST_HL, ST_HL_W, ST_HL_TOP, ST_POP_W, ST_POP_T, ST_DN, ST_DN_W, ST_DN_C
  } state_t;

  // memories
  sst_t ss_mem [WHEEL_SLOTS];
  ent_t en_mem [WHEEL_SLOTS * SLOT_DEPTH];
  ent_t hp_mem [HEAP_DEPTH];

  logic          ss_we;
  logic [PW-1:0] ss_waddr;
  sst_t          ss_wdata;
  logic [PW-1:0] ss_raddr;
  sst_t          ss_rd;

  logic           en_we;
  logic [EAW-1:0] en_waddr;
  ent_t           en_wdata;
  logic [EAW-1:0] en_raddr;
  ent_t           en_rd;

  logic           hp_we;
  logic [HIW-1:0] hp_waddr;
  ent_t           hp_wdata;
  logic [HIW-1:0] hp_ra;
  logic [HIW-1:0] hp_rb;
  ent_t           hp_da;
  ent_t           hp_db;

  // control and working registers
  state_t         state;
  logic [TMW-1:0] base_time;
  logic [PW-1:0]  pos;
  logic [HCW-1:0] heap_count;
  logic [PW-1:0]  clr_idx;
  logic           hl;
  logic [TMW-1:0] cur_due;
  logic [TW-1:0]  cur_tok;
  logic           in_win;
  logic [PW-1:0]  off_lo;
  logic [PW-1:0]  sl;
  logic [1:0]     res_kind;
  logic [HIW-1:0] hi;
  logic [HIW-1:0] pi;
  logic [CXW-1:0] ci;
  logic [HW-1:0]  th;
  logic [CW-1:0]  tc;

  // result register
  logic           ov;
  logic [1:0]     o_kind;
  logic [TW-1:0]  o_tok;
  logic [TMW-1:0] o_due;
  logic           o_last;
  logic           out_free;

  // combinational helpers
  logic [TMW:0]   due_sum;
  logic [TMW-1:0] off_diff;
  logic           off_ge;
  logic [PW:0]    slot_sum;
  logic [PW-1:0]  slot_sel;
  logic [CW:0]    tail_sum;
  logic [HW-1:0]  tail_idx;
  logic [HW:0]    head_inc;
  logic [CXW-1:0] c_idx;
  logic [CXW-1:0] hc_x;
  logic           use_b;
  ent_t           pick;
  logic [HIW-1:0] pick_idx;

  assign out_free = !ov || sched_out.ready;
  assign clearing = (state == ST_CLEAR);
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;

  assign sched_out.valid     = ov;
  assign sched_out.kind      = o_kind;
  assign sched_out.out_token = 16'(o_tok);
  assign sched_out.due_time  = o_due;
  assign sched_out.last      = o_last;

  // memory ports, reads registered
  always_ff @(posedge clk) begin
    if (ss_we) begin
      ss_mem[ss_waddr] <= ss_wdata;
    end
    ss_rd <= ss_mem[ss_raddr];
  end

  always_ff @(posedge clk) begin
    if (en_we) begin
      en_mem[en_waddr] <= en_wdata;
    end
    en_rd <= en_mem[en_raddr];
  end

  always_ff @(posedge clk) begin
    if (hp_we) begin
      hp_mem[hp_waddr] <= hp_wdata;
    end
    hp_da <= hp_mem[hp_ra];
    hp_db <= hp_mem[hp_rb];
  end

  // arithmetic for the current step
  always_comb begin
    due_sum  = {1'b0, base_time} + (TMW + 1)'(cmd.delay);
    off_ge   = (cur_due >= base_time);
    off_diff = cur_due - base_time;
    slot_sum = {1'b0, pos} + {1'b0, off_lo};
    slot_sel = (slot_sum >= (PW + 1)'(WHEEL_SLOTS)) ?
               PW'(slot_sum - (PW + 1)'(WHEEL_SLOTS)) : PW'(slot_sum);
    tail_sum = (CW + 1)'(ss_rd.head) + (CW + 1)'(ss_rd.count);
    tail_idx = (tail_sum >= (CW + 1)'(SLOT_DEPTH)) ?
               HW'(tail_sum - (CW + 1)'(SLOT_DEPTH)) : HW'(tail_sum);
    head_inc = (HW + 1)'(th) + (HW + 1)'(1);
    c_idx    = ((CXW)'(hi) << 1) + (CXW)'(1);
    hc_x     = (CXW)'(heap_count);
    use_b    = ((ci + (CXW)'(1)) < hc_x) &&
               twsched_pkg::earlier(hp_db.due, 16'(hp_db.tok), hp_da.due, 16'(hp_da.tok));
    pick     = use_b ? hp_db : hp_da;
    pick_idx = use_b ? HIW'(ci + (CXW)'(1)) : HIW'(ci);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      base_time  <= '0;
      pos        <= '0;
      heap_count <= '0;
      clr_idx    <= '0;
      ov         <= 1'b0;
      ss_we      <= 1'b0;
      en_we      <= 1'b0;
      hp_we      <= 1'b0;
    end else begin
      ss_we <= 1'b0;
      en_we <= 1'b0;
      hp_we <= 1'b0;
      if (sched_out.ready) begin
        ov <= 1'b0;
      end
      case (state)
        // zero slot state one slot a cycle
        ST_CLEAR: begin
          ss_we    <= 1'b1;
          ss_waddr <= clr_idx;
          ss_wdata <= '0;
          clr_idx  <= clr_idx + PW'(1);
          if (clr_idx == PW'(WHEEL_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end

        // take the next command and form its due time
        ST_IDLE: begin
          if (cmd_valid) begin
            hl      <= 1'b0;
            cur_tok <= TW'(cmd.token);
            if (cmd.op == twsched_pkg::OP_TICK) begin
              ss_raddr <= pos;
              state    <= ST_TK_W;
            end else begin
              if (cmd.op == twsched_pkg::OP_ABS) begin
                cur_due <= cmd.target;
              end else if (cmd.delay[twsched_pkg::DELAY_W-1]) begin
                cur_due <= base_time;
              end else if (due_sum[TMW]) begin
                cur_due <= '1;
              end else begin
                cur_due <= due_sum[TMW-1:0];
              end
              state <= ST_OFF;
            end
          end
        end

        // offset from base time, past clamps to zero
        ST_OFF: begin
          in_win <= !off_ge || (off_diff < TMW'(WHEEL_SLOTS));
          off_lo <= off_ge ? off_diff[PW-1:0] : '0;
          state  <= ST_SLOT;
        end

        // wheel slot or heap
        ST_SLOT: begin
          if (in_win) begin
            sl       <= slot_sel;
            ss_raddr <= slot_sel;
            state    <= ST_SLOT_W;
          end else if (hl) begin
            state <= ST_IDLE;
          end else if (heap_count == HCW'(HEAP_DEPTH)) begin
            res_kind <= twsched_pkg::KIND_REJECT;
            state    <= ST_EMIT;
          end else begin
            hi         <= HIW'(heap_count);
            heap_count <= heap_count + HCW'(1);
            state      <= ST_UP;
          end
        end

        ST_SLOT_W: state <= ST_PUSH;

        // append to the slot FIFO
        ST_PUSH: begin
          if (ss_rd.count == CW'(SLOT_DEPTH)) begin
            res_kind <= twsched_pkg::KIND_REJECT;
            state    <= hl ? ST_IDLE : ST_EMIT;
          end else begin
            en_we          <= 1'b1;
            en_waddr       <= EAW'(EAW'(sl) * EAW'(SLOT_DEPTH)) + EAW'(tail_idx);
            en_wdata.due   <= cur_due;
            en_wdata.tok   <= cur_tok;
            ss_we          <= 1'b1;
            ss_waddr       <= sl;
            ss_wdata.head  <= ss_rd.head;
            ss_wdata.count <= ss_rd.count + CW'(1);
            if (hl) begin
              // hotloaded timer leaves the heap
              heap_count <= heap_count - HCW'(1);
              if (heap_count == HCW'(1)) begin
                state <= ST_IDLE;
              end else begin
                hp_ra <= HIW'(heap_count - HCW'(1));
                state <= ST_POP_W;
              end
            end else begin
              res_kind <= twsched_pkg::KIND_ACCEPT;
              state    <= ST_EMIT;
            end
          end
        end

        // heap sift-up
        ST_UP: begin
          if (hi == '0) begin
            hp_we          <= 1'b1;
            hp_waddr       <= '0;
            hp_wdata.due   <= cur_due;
            hp_wdata.tok   <= cur_tok;
            res_kind       <= twsched_pkg::KIND_ACCEPT;
            state          <= ST_EMIT;
          end else begin
            hp_ra <= (hi - HIW'(1)) >> 1;
            pi    <= (hi - HIW'(1)) >> 1;
            state <= ST_UP_W;
          end
        end

        ST_UP_W: state <= ST_UP_C;

        ST_UP_C: begin
          hp_we    <= 1'b1;
          hp_waddr <= hi;
          if (twsched_pkg::earlier(cur_due, 16'(cur_tok), hp_da.due, 16'(hp_da.tok))) begin
            hp_wdata <= hp_da;
            hi       <= pi;
            state    <= ST_UP;
          end else begin
            hp_wdata.due <= cur_due;
            hp_wdata.tok <= cur_tok;
            res_kind     <= twsched_pkg::KIND_ACCEPT;
            state        <= ST_EMIT;
          end
        end

        // single schedule result
        ST_EMIT: begin
          if (out_free) begin
            ov     <= 1'b1;
            o_kind <= res_kind;
            o_tok  <= cur_tok;
            o_due  <= cur_due;
            o_last <= 1'b1;
            state  <= ST_IDLE;
          end
        end

        // tick: drain the current slot
        ST_TK_W: state <= ST_TK;

        ST_TK: begin
          th    <= ss_rd.head;
          tc    <= ss_rd.count;
          state <= ST_TK_RD;
        end

        ST_TK_RD: begin
          if (tc == '0) begin
            state <= ST_TK_END;
          end else begin
            en_raddr <= EAW'(EAW'(pos) * EAW'(SLOT_DEPTH)) + EAW'(th);
            state    <= ST_TK_W2;
          end
        end

        ST_TK_W2: state <= ST_TK_OUT;

        ST_TK_OUT: begin
          if (out_free) begin
            ov     <= 1'b1;
            o_kind <= twsched_pkg::KIND_FIRED;
            o_tok  <= en_rd.tok;
            o_due  <= en_rd.due;
            o_last <= (tc == CW'(1));
            th     <= (head_inc >= (HW + 1)'(SLOT_DEPTH)) ? '0 : HW'(head_inc);
            tc     <= tc - CW'(1);
            state  <= ST_TK_RD;
          end
        end

        // empty the slot and advance the wheel
        ST_TK_END: begin
          ss_we     <= 1'b1;
          ss_waddr  <= pos;
          ss_wdata  <= '0;
          pos       <= (pos == PW'(WHEEL_SLOTS - 1)) ? '0 : pos + PW'(1);
          base_time <= base_time + TMW'(1);
          state     <= ST_HL;
        end

        // hotload: look at the heap top
        ST_HL: begin
          if (heap_count == '0) begin
            state <= ST_IDLE;
          end else begin
            hp_ra <= '0;
            state <= ST_HL_W;
          end
        end

        ST_HL_W: state <= ST_HL_TOP;

        ST_HL_TOP: begin
          cur_due <= hp_da.due;
          cur_tok <= hp_da.tok;
          hl      <= 1'b1;
          state   <= ST_OFF;
        end

        // pop: last entry sifts down from the root
        ST_POP_W: state <= ST_POP_T;

        ST_POP_T: begin
          cur_due <= hp_da.due;
          cur_tok <= hp_da.tok;
          hi      <= '0;
          state   <= ST_DN;
        end

        ST_DN: begin
          if (c_idx >= hc_x) begin
            hp_we        <= 1'b1;
            hp_waddr     <= hi;
            hp_wdata.due <= cur_due;
            hp_wdata.tok <= cur_tok;
            state        <= ST_HL;
          end else begin
            hp_ra <= HIW'(c_idx);
            hp_rb <= ((c_idx + (CXW)'(1)) < hc_x) ? HIW'(c_idx + (CXW)'(1)) : HIW'(c_idx);
            ci    <= c_idx;
            state <= ST_DN_W;
          end
        end

        ST_DN_W: state <= ST_DN_C;

        ST_DN_C: begin
          hp_we    <= 1'b1;
          hp_waddr <= hi;
          if (twsched_pkg::earlier(pick.due, 16'(pick.tok), cur_due, 16'(cur_tok))) begin
            hp_wdata <= pick;
            hi       <= pick_idx;
            state    <= ST_DN;
          end else begin
            hp_wdata.due <= cur_due;
            hp_wdata.tok <= cur_tok;
            state        <= ST_HL;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/twsched_checker.sv =====
// ----------------------------------------------------------------------------
// twsched_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module twsched_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] out_token,
  input logic [47:0] due_time,
  input logic        last
);

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_token)
                                && $stable(due_time) && $stable(last))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // kind is a defined code
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == twsched_pkg::KIND_FIRED) || (kind == twsched_pkg::KIND_ACCEPT)
                  || (kind == twsched_pkg::KIND_REJECT))
    else $error("bad result kind");

  // schedule answers are single results
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != twsched_pkg::KIND_FIRED) |-> last)
    else $error("schedule result without last");

endmodule

bind timing_wheel_scheduler twsched_checker u_twsched_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (sched_out.valid),
  .out_ready (sched_out.ready),
  .kind      (sched_out.kind),
  .out_token (sched_out.out_token),
  .due_time  (sched_out.due_time),
  .last      (sched_out.last)
);
